>>> rtl/core/jse_pkg.sv
// Package for the JSON string escaper: character codes, run descriptor type
// and small helper functions shared by the front, queue and back modules.
// No dependencies.
package jse_pkg;

  localparam int RUN_W = 4;  // up to 9 output bytes for one input beat

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CTRL_LAST = 8'h1F;
  localparam logic [7:0] LTR_B     = 8'h62;
  localparam logic [7:0] LTR_F     = 8'h66;
  localparam logic [7:0] LTR_N     = 8'h6E;
  localparam logic [7:0] LTR_R     = 8'h72;
  localparam logic [7:0] LTR_T     = 8'h74;
  localparam logic [7:0] LTR_U     = 8'h75;
  localparam logic [7:0] DIG_0     = 8'h30;
  localparam logic [7:0] DIG_2     = 8'h32;
  localparam logic [7:0] DIG_8     = 8'h38;
  localparam logic [7:0] DIG_9     = 8'h39;
  localparam logic [7:0] SEQ_LEAD  = 8'hE2;
  localparam logic [7:0] SEQ_MID   = 8'h80;
  localparam logic [7:0] SEQ_LS    = 8'hA8;
  localparam logic [7:0] SEQ_PS    = 8'hA9;

  typedef enum logic [2:0] {
    BODY_NONE,
    BODY_RAW,
    BODY_ESC,
    BODY_UHEX,
    BODY_U20
  } body_kind_t;

  // One entry per input beat that produces output.
  typedef struct packed {
    logic             start_quote;
    logic [1:0]       pre_flush;
    body_kind_t       body;
    logic [7:0]       body_byte;
    logic [1:0]       post_flush;
    logic             end_quote;
    logic [RUN_W-1:0] run_len;
  } run_desc_t;

  function automatic logic [2:0] body_len(body_kind_t kind);
    logic [2:0] len;
    case (kind)
      BODY_RAW:  len = 3'd1;
      BODY_ESC:  len = 3'd2;
      BODY_UHEX: len = 3'd6;
      BODY_U20:  len = 3'd6;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) c = DIG_0 + {4'h0, v};
    else           c = 8'h37 + {4'h0, v};
    return c;
  endfunction

endpackage

>>> rtl/core/jse_front.sv
// Front of the JSON string escaper: accepts input beats, tracks the held
// E2 / E2 80 prefix and classifies each beat into a run descriptor.
// Depends on jse_pkg.
module jse_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                byte_valid,
  input  logic                string_start,
  input  logic                string_end,
  input  logic                q_full,
  output logic                push,
  output jse_pkg::run_desc_t  push_desc
);
  import jse_pkg::*;

  logic [1:0] held, held_next;
  logic [1:0] h0, after, pre, post;
  logic       fresh;
  body_kind_t kind;
  logic [7:0] bb;
  logic       accept;

  always_comb begin
    h0    = string_start ? 2'd0 : held;
    pre   = 2'd0;
    kind  = BODY_NONE;
    bb    = data_byte;
    after = h0;
    fresh = 1'b0;
    if (byte_valid) begin
      if (h0 == 2'd0) begin
        fresh = 1'b1;
      end else if (h0 == 2'd1) begin
        if (data_byte == SEQ_MID) begin
          after = 2'd2;
        end else begin
          pre   = 2'd1;
          fresh = 1'b1;
        end
      end else if (data_byte == SEQ_LS || data_byte == SEQ_PS) begin
        kind  = BODY_U20;
        bb    = (data_byte == SEQ_LS) ? DIG_8 : DIG_9;
        after = 2'd0;
      end else begin
        pre   = 2'd2;
        fresh = 1'b1;
      end
    end
    if (fresh) begin
      after = 2'd0;
      if (data_byte == SEQ_LEAD) begin
        after = 2'd1;
      end else begin
        case (data_byte) inside
          CH_QUOTE, CH_BSLASH: kind = BODY_ESC;
          CH_BS:  begin kind = BODY_ESC; bb = LTR_B; end
          CH_FF:  begin kind = BODY_ESC; bb = LTR_F; end
          CH_LF:  begin kind = BODY_ESC; bb = LTR_N; end
          CH_CR:  begin kind = BODY_ESC; bb = LTR_R; end
          CH_TAB: begin kind = BODY_ESC; bb = LTR_T; end
          [8'h00:CTRL_LAST]: kind = BODY_UHEX;
          default: kind = BODY_RAW;
        endcase
      end
    end
    post      = string_end ? after : 2'd0;
    held_next = string_end ? 2'd0 : after;
  end

  always_comb begin
    push_desc.start_quote = string_start;
    push_desc.pre_flush   = pre;
    push_desc.body        = kind;
    push_desc.body_byte   = bb;
    push_desc.post_flush  = post;
    push_desc.end_quote   = string_end;
    push_desc.run_len     = {3'b000, string_start} + {2'b00, pre} + {1'b0, body_len(kind)}
                          + {2'b00, post} + {3'b000, string_end};
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && (push_desc.run_len != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 2'd0;
    end else if (accept) begin
      held <= held_next;
    end
  end

endmodule

>>> rtl/core/jse_queue.sv
// Two-entry queue of run descriptors between the escaper's front and back.
// Depends on jse_pkg.
module jse_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  jse_pkg::run_desc_t  push_desc,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output jse_pkg::run_desc_t  head_desc
);
  import jse_pkg::*;

  run_desc_t  slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_desc  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/jse_back.sv
// Back of the JSON string escaper: walks the head run descriptor one byte
// per cycle unless stalled into a registered beat. Depends on jse_pkg.
module jse_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  jse_pkg::run_desc_t  head_desc,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_char,
  output logic                run_last,
  output logic                string_done
);
  import jse_pkg::*;

  logic [RUN_W-1:0] idx;
  logic [RUN_W-1:0] p1, p2, p3;
  logic [2:0]       blen;
  logic [7:0]       ch, body_ch;
  logic             last, load;

  always_comb begin
    case (head_desc.body)
      BODY_RAW: body_ch = head_desc.body_byte;
      BODY_ESC: body_ch = (p2 == '0) ? CH_BSLASH : head_desc.body_byte;
      BODY_UHEX: begin
        case (p2[2:0])
          3'd0:    body_ch = CH_BSLASH;
          3'd1:    body_ch = LTR_U;
          3'd2:    body_ch = DIG_0;
          3'd3:    body_ch = DIG_0;
          3'd4:    body_ch = hex_digit(head_desc.body_byte[7:4]);
          default: body_ch = hex_digit(head_desc.body_byte[3:0]);
        endcase
      end
      BODY_U20: begin
        case (p2[2:0])
          3'd0:    body_ch = CH_BSLASH;
          3'd1:    body_ch = LTR_U;
          3'd2:    body_ch = DIG_2;
          3'd3:    body_ch = DIG_0;
          3'd4:    body_ch = DIG_2;
          default: body_ch = head_desc.body_byte;
        endcase
      end
      default: body_ch = head_desc.body_byte;
    endcase
  end

  // Locate idx within the segments: quote, flush, body, flush, quote.
  always_comb begin
    blen = body_len(head_desc.body);
    p1   = idx - {3'b000, head_desc.start_quote};
    p2   = p1 - {2'b00, head_desc.pre_flush};
    p3   = p2 - {1'b0, blen};
    if (head_desc.start_quote && idx == '0) begin
      ch = CH_QUOTE;
    end else if (p1 < {2'b00, head_desc.pre_flush}) begin
      ch = (p1 == '0) ? SEQ_LEAD : SEQ_MID;
    end else if (p2 < {1'b0, blen}) begin
      ch = body_ch;
    end else if (p3 < {2'b00, head_desc.post_flush}) begin
      ch = (p3 == '0) ? SEQ_LEAD : SEQ_MID;
    end else begin
      ch = CH_QUOTE;
    end
  end

  assign last = (idx == head_desc.run_len - 4'd1);
  assign load = !out_valid || !out_stall;
  assign pop  = load && head_valid && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) idx <= last ? '0 : idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_char    <= ch;
      run_last    <= last;
      string_done <= last && head_desc.end_quote;
    end
  end

endmodule

>>> rtl/core/json_string_escaper.sv
// Top level of the JSON string escaper: front classifier, descriptor queue
// and output sequencer. Depends on jse_pkg, jse_front, jse_queue, jse_back.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | data_byte, byte_valid, string_start,
//           |                      | string_end
//   out     | out_valid / out_stall| out_char, run_last, string_done
//
// One output beat per cycle from the back sequencer while out_stall is low;
// an input beat with n results (1 to 9) holds the back until all n are
// sent, so plain bytes flow at one per cycle. Beats with no result are not queued.
// in_stall rises when the two-entry descriptor queue is full.
// Synchronous active-high reset clears the held prefix, queue and output.
module json_string_escaper (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       byte_valid,
  input  logic       string_start,
  input  logic       string_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       run_last,
  output logic       string_done
);
  import jse_pkg::*;

  logic      push, q_full, pop, head_valid;
  run_desc_t push_desc, head_desc;

  jse_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .byte_valid   (byte_valid),
    .string_start (string_start),
    .string_end   (string_end),
    .q_full       (q_full),
    .push         (push),
    .push_desc    (push_desc)
  );

  jse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  jse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_desc   (head_desc),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .run_last    (run_last),
    .string_done (string_done)
  );

endmodule
